>>> hdl/dtq_pkg.sv
// ============================================================================
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ============================================================================
package dtq_pkg;

    // Field widths
    localparam int TIME_BITS       = 48;
    localparam int ID_BITS         = 8;
    localparam int IN_DATA_BITS    = 104;   // id + deadline + now_time
    localparam int OUT_DATA_BITS   = 56;    // id + deadline

    // Table sizing
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_BITS        = $clog2(MAX_RESULTS);

    // Input kind (tuser on the slave side)
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    // Result status (tuser on the master side)
    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_EXPIRED  = 2'd2,
        ST_NONE_DUE = 2'd3
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_TICK = 1'b1
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic    insert;     // sorted insert of the incoming timer
        logic    pop;        // remove head, shift table down
        logic    latch_now;  // capture tick time
        logic    load_out;   // load output register
        t_status status;
        logic    last;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic full;      // last slot occupied
        logic due0;      // head is due
        logic due1;      // entry behind head is due
        logic out_free;  // output register can take a beat
    } t_sts;

endpackage

>>> hdl/dtq_ctrl.sv
// ============================================================================
// dtq_ctrl
// Controller: accepts beats, sequences inserts and tick drains.
// ============================================================================
module dtq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    input  dtq_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output dtq_pkg::t_cmd  o_cmd
);

    dtq_pkg::t_state               r_state, n_state;
    logic [dtq_pkg::CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                          w_accept;
    logic                          w_last_exp;
    dtq_pkg::t_op                  w_op;

    assign w_op       = dtq_pkg::t_op'(i_in_op);
    assign o_in_ready = (r_state == dtq_pkg::S_IDLE) && i_sts.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Final expired beat: nothing more due or emit limit reached
    assign w_last_exp = !i_sts.due1 ||
                        (r_cnt == dtq_pkg::CNT_BITS'(dtq_pkg::MAX_RESULTS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (w_accept && w_op == dtq_pkg::OP_TICK) begin
                    n_state = dtq_pkg::S_TICK;
                    n_cnt   = '0;
                end
            end
            dtq_pkg::S_TICK: begin
                if (i_sts.out_free) begin
                    if (!i_sts.due0 || w_last_exp) begin
                        n_state = dtq_pkg::S_IDLE;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '{insert: 1'b0, pop: 1'b0, latch_now: 1'b0, load_out: 1'b0,
                  status: dtq_pkg::ST_ACCEPTED, last: 1'b1};
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_op == dtq_pkg::OP_INSERT) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.insert   = !i_sts.full;
                        o_cmd.status   = i_sts.full ? dtq_pkg::ST_FULL
                                                    : dtq_pkg::ST_ACCEPTED;
                    end else begin
                        o_cmd.latch_now = 1'b1;
                    end
                end
            end
            dtq_pkg::S_TICK: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.due0) begin
                        o_cmd.pop    = 1'b1;
                        o_cmd.status = dtq_pkg::ST_EXPIRED;
                        o_cmd.last   = w_last_exp;
                    end else begin
                        o_cmd.status = dtq_pkg::ST_NONE_DUE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> hdl/dtq_datapath.sv
// ============================================================================
// dtq_datapath
// Sorted cell chain of timers, tick time register and output register.
// ============================================================================
module dtq_datapath #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtq_pkg::t_cmd                    i_cmd,
    input  logic [dtq_pkg::ID_BITS-1:0]      i_timer_id,
    input  logic [dtq_pkg::TIME_BITS-1:0]    i_deadline,
    input  logic [dtq_pkg::TIME_BITS-1:0]    i_now_time,
    input  logic                             i_out_ready,
    output dtq_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output dtq_pkg::t_status                 o_out_status,
    output logic [dtq_pkg::ID_BITS-1:0]      o_out_id,
    output logic [dtq_pkg::TIME_BITS-1:0]    o_out_deadline,
    output logic                             o_out_last
);

    localparam int TB = dtq_pkg::TIME_BITS;
    localparam int IB = dtq_pkg::ID_BITS;

    // Cell storage
    logic [TB-1:0]          r_dl [QUEUE_DEPTH];
    logic [IB-1:0]          r_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [TB-1:0]          n_dl [QUEUE_DEPTH];
    logic [IB-1:0]          n_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] n_valid;

    // Neighbor views: up = cell g-1, dn = cell g+1
    logic [TB-1:0]          w_up_dl [QUEUE_DEPTH];
    logic [IB-1:0]          w_up_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_up_valid;
    logic [QUEUE_DEPTH-1:0] w_up_place;
    logic [TB-1:0]          w_dn_dl [QUEUE_DEPTH];
    logic [IB-1:0]          w_dn_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_dn_valid;
    logic [QUEUE_DEPTH-1:0] w_place;

    logic [TB-1:0]          r_now;

    logic                   r_out_valid;
    dtq_pkg::t_status       r_out_status;
    logic [IB-1:0]          r_out_id;
    logic [TB-1:0]          r_out_dl;
    logic                   r_out_last;

    // Per-cell compare: new timer goes at or before this cell
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            assign w_place[g] = !r_valid[g] || (r_dl[g] > i_deadline);
            if (g == 0) begin : g_head
                assign w_up_dl[g]    = '0;
                assign w_up_id[g]    = '0;
                assign w_up_valid[g] = 1'b1;
                assign w_up_place[g] = 1'b0;
            end else begin : g_body
                assign w_up_dl[g]    = r_dl[g-1];
                assign w_up_id[g]    = r_id[g-1];
                assign w_up_valid[g] = r_valid[g-1];
                assign w_up_place[g] = w_place[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_dn_dl[g]    = r_dl[g];
                assign w_dn_id[g]    = r_id[g];
                assign w_dn_valid[g] = 1'b0;
            end else begin : g_inner
                assign w_dn_dl[g]    = r_dl[g+1];
                assign w_dn_id[g]    = r_id[g+1];
                assign w_dn_valid[g] = r_valid[g+1];
            end
        end
    endgenerate

    // Next cell contents: shift up on insert, shift down on pop
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_dl[i]    = r_dl[i];
            n_id[i]    = r_id[i];
            n_valid[i] = r_valid[i];
            if (i_cmd.insert) begin
                if (w_place[i]) begin
                    if (w_up_place[i]) begin
                        n_dl[i] = w_up_dl[i];
                        n_id[i] = w_up_id[i];
                    end else begin
                        n_dl[i] = i_deadline;
                        n_id[i] = i_timer_id;
                    end
                end
                n_valid[i] = r_valid[i] | w_up_valid[i];
            end else if (i_cmd.pop) begin
                n_dl[i]    = w_dn_dl[i];
                n_id[i]    = w_dn_id[i];
                n_valid[i] = w_dn_valid[i];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Cell payload and tick time
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_dl[i] <= n_dl[i];
            r_id[i] <= n_id[i];
        end
        if (i_cmd.latch_now) begin
            r_now <= i_now_time;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
            r_out_id     <= i_cmd.pop ? r_id[0] : '0;
            r_out_dl     <= i_cmd.pop ? r_dl[0] : '0;
        end
    end

    // Status to controller
    assign o_sts.full     = r_valid[QUEUE_DEPTH-1];
    assign o_sts.due0     = r_valid[0] && (r_dl[0] <= r_now);
    assign o_sts.due1     = r_valid[1] && (r_dl[1] <= r_now);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_id       = r_out_id;
    assign o_out_deadline = r_out_dl;
    assign o_out_last     = r_out_last;

endmodule

>>> hdl/deadline_timer_queue.sv
// Insert: result beat is registered on accept; a new beat waits until the output is free.
// Tick: the time is captured first, then the head cell emits one expired timer per cycle
//   while the output is free, up to 16 per tick, or a none-due beat if none is due.
// Rate is set by the sorted chain's head cell: one timer per cycle while output is free.
// Reset (synchronous, active low) empties the table and the output register at once.
// Stored deadlines and handles are not cleared; only occupied cells are ever read.
// ============================================================================
// deadline_timer_queue
// Timer table kept sorted by deadline; emits due timers in order on a tick.
// ============================================================================
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [7:0] timer_id, [55:8] deadline, [103:56] now_time
    input  logic [dtq_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // tuser: [0] op
    input  logic                                i_s_axis_tuser,
    // Master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: [7:0] expired_id, [55:8] expired_deadline
    output logic [dtq_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata,
    // tuser: [1:0] status
    output logic [1:0]                          o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    localparam int TB = dtq_pkg::TIME_BITS;
    localparam int IB = dtq_pkg::ID_BITS;

    dtq_pkg::t_cmd     w_cmd;
    dtq_pkg::t_sts     w_sts;
    dtq_pkg::t_status  w_out_status;
    logic [IB-1:0]     w_out_id;
    logic [TB-1:0]     w_out_dl;

    // Controller
    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    dtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_timer_id     (i_s_axis_tdata[IB-1:0]),
        .i_deadline     (i_s_axis_tdata[IB+TB-1:IB]),
        .i_now_time     (i_s_axis_tdata[IB+2*TB-1:IB+TB]),
        .i_out_ready    (i_m_axis_tready),
        .o_sts          (w_sts),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_status   (w_out_status),
        .o_out_id       (w_out_id),
        .o_out_deadline (w_out_dl),
        .o_out_last     (o_m_axis_tlast)
    );

    // Result beat packing
    assign o_m_axis_tdata = {w_out_dl, w_out_id};
    assign o_m_axis_tuser = w_out_status;

endmodule
